// ===== hdl/ssr_pkg.sv =====
// Shared types and constants for the stepped speed regulator.
package ssr_pkg;

	localparam int AddrWidth = 5;

	localparam logic [2:0] REG_MIN_SPEED       = 3'd0;
	localparam logic [2:0] REG_MAX_SPEED       = 3'd1;
	localparam logic [2:0] REG_MAX_DUTY        = 3'd2;
	localparam logic [2:0] REG_MIN_DUTY        = 3'd3;
	localparam logic [2:0] REG_STARTUP_CURRENT = 3'd4;
	localparam logic [2:0] REG_NO_SPEED_TICKS  = 3'd5;
	localparam logic [2:0] REG_SLOW_SPD_TICKS  = 3'd6;

	localparam logic [7:0]  RST_MIN_SPEED       = 8'd5;
	localparam logic [7:0]  RST_MAX_SPEED       = 8'd30;
	localparam logic [9:0]  RST_MAX_DUTY        = 10'd800;
	localparam logic [9:0]  RST_MIN_DUTY        = 10'd50;
	localparam logic [11:0] RST_STARTUP_CURRENT = 12'd500;
	localparam logic [15:0] RST_NO_SPEED_TICKS  = 16'd100;
	localparam logic [15:0] RST_SLOW_SPD_TICKS  = 16'd60;

	localparam logic [7:0] SOFT_START_TICKS = 8'd2;
	localparam logic [7:0] REGULATE_TICK    = 8'd4;
	localparam logic [7:0] STALL_TICK       = 8'd20;
	localparam logic [7:0] RUN_TICKS_MAX    = 8'd250;
	localparam logic [3:0] GOOD_SPEED_LIMIT = 4'd10;

	localparam logic [1:0] DRIVE_OFF  = 2'd0;
	localparam logic [1:0] DRIVE_UP   = 2'd1;
	localparam logic [1:0] DRIVE_DOWN = 2'd2;

	typedef struct packed {
		logic        run;
		logic        dir_up;
		logic [7:0]  speed;
		logic [11:0] current_ma;
		logic [15:0] position;
		logic        slow_stop_active;
	} in_item_t;

	typedef struct packed {
		logic [9:0] duty;
		logic [1:0] drive;
		logic       brake;
		logic       stall_stop;
		logic [7:0] target_now;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  spd_floor;
		logic [7:0]  spd_ceiling;
		logic [9:0]  duty_ceiling;
		logic [9:0]  duty_floor;
		logic [11:0] cur_limit;
		logic [15:0] no_speed_ticks;
		logic [15:0] slow_speed_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] high_current_ticks;
		logic [3:0]  good_speed_ticks;
		logic [15:0] window_ticks;
		logic [15:0] position_ref;
	} stall_st_t;

endpackage

// ===== hdl/ssr_cfg.sv =====
// APB register file holding the regulator limits.
module ssr_cfg import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[AddrWidth-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spd_floor        <= RST_MIN_SPEED;
			cfg_q.spd_ceiling      <= RST_MAX_SPEED;
			cfg_q.duty_ceiling     <= RST_MAX_DUTY;
			cfg_q.duty_floor       <= RST_MIN_DUTY;
			cfg_q.cur_limit        <= RST_STARTUP_CURRENT;
			cfg_q.no_speed_ticks   <= RST_NO_SPEED_TICKS;
			cfg_q.slow_speed_ticks <= RST_SLOW_SPD_TICKS;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_SPEED:       cfg_q.spd_floor        <= pwdata[7:0];
				REG_MAX_SPEED:       cfg_q.spd_ceiling      <= pwdata[7:0];
				REG_MAX_DUTY:        cfg_q.duty_ceiling     <= pwdata[9:0];
				REG_MIN_DUTY:        cfg_q.duty_floor       <= pwdata[9:0];
				REG_STARTUP_CURRENT: cfg_q.cur_limit        <= pwdata[11:0];
				REG_NO_SPEED_TICKS:  cfg_q.no_speed_ticks   <= pwdata[15:0];
				REG_SLOW_SPD_TICKS:  cfg_q.slow_speed_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_SPEED:       prdata = {24'd0, cfg_q.spd_floor};
			REG_MAX_SPEED:       prdata = {24'd0, cfg_q.spd_ceiling};
			REG_MAX_DUTY:        prdata = {22'd0, cfg_q.duty_ceiling};
			REG_MIN_DUTY:        prdata = {22'd0, cfg_q.duty_floor};
			REG_STARTUP_CURRENT: prdata = {20'd0, cfg_q.cur_limit};
			REG_NO_SPEED_TICKS:  prdata = {16'd0, cfg_q.no_speed_ticks};
			REG_SLOW_SPD_TICKS:  prdata = {16'd0, cfg_q.slow_speed_ticks};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/ssr_stall.sv =====
// Stall detector next-state logic: high current at low speed, stuck hall position.
module ssr_stall import ssr_pkg::*; (
	input  cfg_t        cfg,
	input  logic [7:0]  speed,
	input  logic [11:0] current_ma,
	input  logic [15:0] position,
	input  stall_st_t   st,
	output stall_st_t   st_next,
	output logic        hit
);

	logic               high_cur;
	logic [15:0]        hc_inc;
	logic [15:0]        wt_inc;
	logic [3:0]         gs_inc;
	logic signed [16:0] pos_diff;
	logic               pos_near;

	assign high_cur = current_ma >= cfg.cur_limit;
	assign hc_inc   = st.high_current_ticks + 16'd1;
	assign wt_inc   = st.window_ticks + 16'd1;
	assign gs_inc   = st.good_speed_ticks + 4'd1;
	assign pos_diff = $signed({1'b0, position}) - $signed({1'b0, st.position_ref});
	assign pos_near = (pos_diff >= -17'sd2) && (pos_diff <= 17'sd2);

	always_comb begin
		st_next = st;
		hit     = 1'b0;
		if (speed < cfg.spd_floor) begin
			if (high_cur) begin
				st_next.high_current_ticks = hc_inc;
				if (hc_inc >= cfg.no_speed_ticks) begin
					st_next.high_current_ticks = 16'd0;
					st_next.good_speed_ticks   = 4'd0;
					hit                        = 1'b1;
				end
			end else begin
				st_next.high_current_ticks = 16'd0;
				st_next.good_speed_ticks   = 4'd0;
			end
			st_next.window_ticks = wt_inc;
			if (wt_inc >= cfg.slow_speed_ticks) begin
				st_next.good_speed_ticks = 4'd0;
				st_next.window_ticks     = 16'd0;
				st_next.position_ref     = position;
				if (high_cur && pos_near)
					hit = 1'b1;
			end
		end else begin
			st_next.good_speed_ticks = gs_inc;
			if (gs_inc > GOOD_SPEED_LIMIT) begin
				st_next.good_speed_ticks = 4'd0;
				st_next.window_ticks     = 16'd0;
			end
		end
	end

endmodule

// ===== hdl/ssr_core.sv =====
// Regulator state and one control tick of duty stepping, target ramp and stall stop.
module ssr_core import ssr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      fire,
	input  in_item_t  item,
	output out_item_t res
);

	logic [9:0]  duty_q, duty_n;
	logic [7:0]  tgt_q, tgt_n;
	logic [7:0]  prev_q, prev_n;
	logic [7:0]  rt_q, rt_n;
	logic [1:0]  rd_q, rd_n;
	stall_st_t   st_q, st_n, st_chk;
	logic        hit;

	logic signed [10:0] err;
	logic [8:0]         mag;
	logic               pos_err;
	logic [4:0]         step;
	logic [10:0]        d_up;
	logic [9:0]         duty_a;
	logic [1:0]         rd_inc;

	ssr_stall u_stall (
		.cfg        (cfg),
		.speed      (item.speed),
		.current_ma (item.current_ma),
		.position   (item.position),
		.st         (st_q),
		.st_next    (st_chk),
		.hit        (hit)
	);

	assign err = $signed({2'b00, tgt_q, 1'b0}) - $signed({3'b000, item.speed})
	           - $signed({3'b000, prev_q});
	assign pos_err = ~err[10];
	assign mag     = pos_err ? err[8:0] : 9'(-err);

	always_comb begin
		if (mag > 9'd20)      step = pos_err ? 5'd30 : 5'd20;
		else if (mag > 9'd16) step = pos_err ? 5'd15 : 5'd10;
		else if (mag > 9'd12) step = pos_err ? 5'd6 : 5'd5;
		else if (mag > 9'd6)  step = 5'd2;
		else if (mag > 9'd2)  step = 5'd1;
		else                  step = 5'd0;
	end

	assign d_up   = {1'b0, duty_q} + {6'd0, step};
	assign rd_inc = rd_q + 2'd1;

	always_comb begin
		if (pos_err)
			duty_a = (d_up > {1'b0, cfg.duty_ceiling}) ? cfg.duty_ceiling : d_up[9:0];
		else if (duty_q > {5'd0, step})
			duty_a = duty_q - {5'd0, step};
		else
			duty_a = duty_q;
	end

	always_comb begin
		logic stall;
		logic slow;
		stall  = 1'b0;
		slow   = item.slow_stop_active;
		duty_n = duty_q;
		tgt_n  = tgt_q;
		prev_n = prev_q;
		rt_n   = rt_q;
		rd_n   = rd_q;
		st_n   = st_q;
		res    = '0;
		if (!item.run) begin
			rt_n      = 8'd0;
			duty_n    = 10'd0;
			res.brake = 1'b1;
		end else begin
			if (rt_q < SOFT_START_TICKS) begin
				tgt_n  = cfg.spd_floor;
				duty_n = cfg.duty_ceiling >> 2;
			end else if (rt_q >= REGULATE_TICK) begin
				duty_n = duty_a;
				if (rt_q >= STALL_TICK) begin
					st_n  = st_chk;
					stall = hit;
				end else begin
					st_n.position_ref       = item.position;
					st_n.high_current_ticks = 16'd0;
					st_n.good_speed_ticks   = 4'd0;
					st_n.window_ticks       = 16'd0;
					slow                    = 1'b0;
				end
				if (!slow && tgt_q < cfg.spd_ceiling) begin
					rd_n = rd_inc;
					if (rd_inc > 2'd2) begin
						tgt_n = tgt_q + 8'd1;
						rd_n  = 2'd0;
					end
				end
				if (duty_n > cfg.duty_ceiling) duty_n = cfg.duty_ceiling;
				if (duty_n < cfg.duty_floor) duty_n = cfg.duty_floor;
				if (stall) begin
					res.stall_stop = 1'b1;
				end else begin
					res.drive = item.dir_up ? DRIVE_UP : DRIVE_DOWN;
					res.duty  = duty_n;
				end
			end
			if (rt_q < RUN_TICKS_MAX) rt_n = rt_q + 8'd1;
			prev_n = item.speed;
		end
		res.target_now = tgt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			tgt_q  <= '0;
			prev_q <= '0;
			rt_q   <= '0;
			rd_q   <= '0;
			st_q   <= '0;
		end else if (fire) begin
			duty_q <= duty_n;
			tgt_q  <= tgt_n;
			prev_q <= prev_n;
			rt_q   <= rt_n;
			rd_q   <= rd_n;
			st_q   <= st_n;
		end
	end

endmodule

// ===== hdl/stepped_speed_regulator_stall_detect.sv =====
// Stepped speed regulator with soft start and stall detection: top level.
//
// Each input transaction is one control tick (run, direction, speed, current,
// hall position, slow-stop). Each tick yields exactly one output transaction
// with duty, drive, brake, stall_stop and the target speed after the tick.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// Path: the tick is registered in the input register on accept, and its result
// is registered in the result register, which drives out_valid and out_item.
// Throughput: one tick per cycle while out_stall is low; the tick logic
// between the input register and the result register is a single pass that
// also updates the regulator state.
// Receiver stall: the result register holds its transaction; the input
// register keeps its tick and in_stall rises until the result is taken.
// Reset: all regulator state clears, the limit registers take their reset
// values, and both stages are empty. The user must write limits over the APB
// port only while no tick is in flight; the block does not enforce this.
module stepped_speed_regulator_stall_detect import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      v_s1;
	out_item_t res;
	out_item_t res_q;
	logic      res_v_q;
	logic      adv;
	logic      fire;
	logic      take;

	ssr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	assign adv      = !res_v_q || !out_stall;
	assign fire     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (take)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				res_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= in_item;
		if (fire)
			res_q <= res;
	end

	assign out_valid = res_v_q;
	assign out_item  = res_q;

endmodule
